// ===== hw/rtl/ir_pulse_width_command_decoder_assert.svh =====
// Assertion macros used by the IR pulse-width decoder message serializer.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef IR_PULSE_WIDTH_COMMAND_DECODER_ASSERT_SVH
`define IR_PULSE_WIDTH_COMMAND_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IRPWD_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define IRPWD_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== hw/rtl/ir_pwd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR pulse-width decoder package
// Types, constants and small lookup functions shared by the decoder modules.
// ----------------------------------------------------------------------------
package ir_pwd_pkg;

	localparam int unsigned FrameBits = 12;
	localparam int unsigned NumButtons = 9;
	localparam int unsigned MsgLen = 7;

	typedef logic [FrameBits-1:0] code_t;
	typedef logic [3:0] button_t;
	typedef logic [2:0] msg_pos_t;
	typedef logic [1:0] cfg_index_t;
	typedef logic [7:0] cfg_data_t;

	// Configuration register indexes.
	localparam cfg_index_t CfgStartThreshold = 2'd0;
	localparam cfg_index_t CfgLevel          = 2'd1;
	localparam cfg_index_t CfgBand           = 2'd2;
	localparam cfg_index_t CfgMono           = 2'd3;

	localparam logic [7:0] StartThresholdReset = 8'd72;
	localparam logic [3:0] LevelReset          = 4'd3;
	localparam logic [1:0] BandReset           = 2'd1;
	localparam logic       MonoReset           = 1'b0;

	// Byte positions within one message.
	localparam msg_pos_t PosHundreds = 3'd0;
	localparam msg_pos_t PosTens     = 3'd1;
	localparam msg_pos_t PosOnes     = 3'd2;
	localparam msg_pos_t PosLevel    = 3'd3;
	localparam msg_pos_t PosBand     = 3'd4;
	localparam msg_pos_t PosMono     = 3'd5;
	localparam msg_pos_t PosNewline  = 3'd6;

	localparam logic [7:0] AsciiZero    = 8'h30;
	localparam logic [7:0] AsciiUpperA  = 8'h41;
	localparam logic [7:0] AsciiNewline = 8'h0A;

	localparam code_t ButtonCodes [NumButtons] = '{
		12'h010, 12'h810, 12'h410, 12'hC10, 12'h210,
		12'hA10, 12'h610, 12'hE10, 12'h110
	};

	// Button frequencies held as three BCD digits.
	localparam logic [11:0] FreqBcd [NumButtons] = '{
		12'h768, 12'h774, 12'h783, 12'h789, 12'h803,
		12'h809, 12'h816, 12'h822, 12'h828
	};

	typedef struct packed {
		logic    found;
		button_t index;
	} button_hit_t;

	// Request from the frame decoder to the message serializer.
	typedef struct packed {
		logic    valid;
		button_t button;
	} msg_req_t;

	function automatic button_hit_t button_lookup(input code_t code);
		button_hit_t hit;
		hit = '0;
		for (int i = 0; i < NumButtons; i++) begin
			if (!hit.found && code == ButtonCodes[i]) begin
				hit.found = 1'b1;
				hit.index = button_t'(i);
			end
		end
		return hit;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		logic [7:0] c;
		if (v <= 4'd9) begin
			c = AsciiZero + {4'd0, v};
		end else begin
			c = AsciiUpperA + {4'd0, v} - 8'd10;
		end
		return c;
	endfunction

	function automatic logic [7:0] msg_char(input button_t button, input msg_pos_t pos,
			input logic [3:0] level, input logic [1:0] band, input logic mono);
		logic [11:0] bcd;
		logic [7:0]  c;
		bcd = (button < button_t'(NumButtons)) ? FreqBcd[button] : 12'd0;
		case (pos)
			PosHundreds: c = AsciiZero + {4'd0, bcd[11:8]};
			PosTens:     c = AsciiZero + {4'd0, bcd[7:4]};
			PosOnes:     c = AsciiZero + {4'd0, bcd[3:0]};
			PosLevel:    c = hex_char(level);
			PosBand:     c = hex_char({band, 2'b00});
			PosMono:     c = AsciiZero + {7'd0, mono};
			PosNewline:  c = AsciiNewline;
			default:     c = AsciiNewline;
		endcase
		return c;
	endfunction

endpackage

// ===== hw/rtl/ir_pwd_edge_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR edge event channel
// Valid/ready channel carrying one receiver edge: new pin level and interval.
// ----------------------------------------------------------------------------
interface ir_pwd_edge_if;
	logic       valid;
	logic       ready;
	logic       pin_level;
	logic [7:0] interval;

	modport source (output valid, pin_level, interval, input ready);
	modport sink (input valid, pin_level, interval, output ready);
endinterface

// ===== hw/rtl/ir_pwd_char_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command character channel
// Valid/ready channel carrying one ASCII byte of a command message.
// ----------------------------------------------------------------------------
interface ir_pwd_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last_char;

	modport source (output valid, out_char, last_char, input ready);
	modport sink (input valid, out_char, last_char, output ready);
endinterface

// ===== hw/rtl/ir_pwd_frame.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR frame decoder
// Registers each edge request, tracks frame start and bit timing, assembles
// the 12-bit code and raises a message request for a confirmed button press.
// ----------------------------------------------------------------------------
module ir_pwd_frame (
	input  logic                  clk,
	input  logic                  arst_n,
	ir_pwd_edge_if.sink           edge_in,
	input  logic [7:0]            start_threshold,
	input  logic                  msg_ready,
	output ir_pwd_pkg::msg_req_t  msg_req
);
	import ir_pwd_pkg::*;

	localparam logic [3:0] LastBit = 4'(FrameBits - 1);

	logic        valid_s1;
	logic        pin_s1;
	logic [7:0]  interval_s1;

	logic        receiving_q;
	logic [7:0]  high_q;
	logic [3:0]  bit_count_q;
	code_t       shift_q;
	code_t       prev_frame_q;
	code_t       last_sent_q;

	logic        bit_val;
	code_t       code;
	logic        frame_done;
	logic        repeat_hit;
	button_hit_t hit;
	logic        emit;
	logic        fire_s1;

	always_comb begin
		bit_val    = {1'b0, interval_s1} > {high_q, 1'b0};
		code       = {shift_q[FrameBits-2:0], bit_val};
		frame_done = receiving_q && pin_s1 && (bit_count_q == LastBit);
		repeat_hit = frame_done && (code == prev_frame_q) && (code != last_sent_q);
		hit        = button_lookup(code);
		emit       = repeat_hit && hit.found;
		// A request that produces a message waits for the serializer.
		fire_s1    = valid_s1 && (!emit || msg_ready);
	end

	assign edge_in.ready  = !valid_s1 || fire_s1;
	assign msg_req.valid  = valid_s1 && emit;
	assign msg_req.button = hit.index;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (edge_in.valid && edge_in.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (edge_in.valid && edge_in.ready) begin
			pin_s1      <= edge_in.pin_level;
			interval_s1 <= edge_in.interval;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q  <= 1'b0;
			high_q       <= '0;
			bit_count_q  <= '0;
			shift_q      <= '0;
			prev_frame_q <= '0;
			last_sent_q  <= '0;
		end else if (fire_s1) begin
			if (!pin_s1) begin
				high_q <= interval_s1;
			end
			if (!receiving_q) begin
				if (pin_s1 && (interval_s1 > start_threshold)) begin
					receiving_q <= 1'b1;
					bit_count_q <= '0;
					shift_q     <= '0;
				end
			end else if (pin_s1) begin
				shift_q     <= code;
				bit_count_q <= bit_count_q + 4'd1;
				if (frame_done) begin
					receiving_q  <= 1'b0;
					prev_frame_q <= code;
					if (repeat_hit) begin
						last_sent_q <= code;
					end
				end
			end
		end
	end

endmodule

// ===== hw/rtl/ir_pwd_msg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command message serializer
// Turns a button request into seven ASCII bytes on the character channel.
// ----------------------------------------------------------------------------
module ir_pwd_msg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ir_pwd_pkg::msg_req_t  msg_req,
	output logic                  msg_ready,
	input  logic [3:0]            level_setting,
	input  logic [1:0]            band_setting,
	input  logic                  mono_setting,
	ir_pwd_char_if.source         char_out
);
	import ir_pwd_pkg::*;

	logic     busy_q;
	msg_pos_t pos_q;
	button_t  button_q;
	logic     out_fire;
	logic     at_last;

	assign at_last   = (pos_q == PosNewline);
	assign out_fire  = char_out.valid && char_out.ready;
	// A new request may load while the newline is being taken.
	assign msg_ready = !busy_q || (out_fire && at_last);

	assign char_out.valid     = busy_q;
	assign char_out.last_char = at_last;
	assign char_out.out_char  = msg_char(button_q, pos_q, level_setting, band_setting,
		mono_setting);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= PosHundreds;
		end else if (msg_req.valid && msg_ready) begin
			busy_q <= 1'b1;
			pos_q  <= PosHundreds;
		end else if (out_fire) begin
			if (at_last) begin
				busy_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (msg_req.valid && msg_ready) begin
			button_q <= msg_req.button;
		end
	end

`include "ir_pulse_width_command_decoder_assert.svh"

	`IRPWD_ASSERT_NEXT(a_load_starts, msg_req.valid && msg_ready, busy_q && pos_q == PosHundreds, "message load did not start at first byte")
	`IRPWD_ASSERT_NEXT(a_mid_keeps_busy, out_fire && !at_last, busy_q && pos_q != PosHundreds, "message ended before newline")
	`IRPWD_ASSERT_NOW(a_idle_pos, !busy_q, pos_q == PosHundreds || pos_q == PosNewline, "idle serializer left mid message")

endmodule

// ===== hw/rtl/ir_pulse_width_command_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR pulse-width command decoder
// Decodes 12-bit IR remote frames from edge events and sends button messages.
// ----------------------------------------------------------------------------
// Usage:
//   edge_in carries receiver edge requests (pin level after the edge, ticks
//   since the previous edge). char_out carries the ASCII command bytes; the
//   newline byte has last_char set. The user writes registers through cfg_we,
//   cfg_index and cfg_wdata only while the block is idle; it is not enforced.
//   An edge request is registered at acceptance and decoded in the following
//   cycle; a new edge may be accepted every cycle unless a message-producing
//   edge waits for the serializer. An edge that completes a confirmed button
//   frame loads the serializer, whose registers drive the first byte; bytes
//   follow at one per cycle when char_out is ready, seven per message. The
//   serializer sets the pace: an edge that starts a new message waits until
//   the previous newline is taken, and later edges wait behind it.
//   When char_out stalls, the current byte holds and edge requests keep
//   flowing until a message-producing edge reaches decode.
//   Reset clears frame state, the message serializer and the registers to
//   threshold 72, level 3, band 1, mono 0. No clearing pass is needed.
// ----------------------------------------------------------------------------
module ir_pulse_width_command_decoder (
	input  logic                    clk,
	input  logic                    arst_n,
	ir_pwd_edge_if.sink             edge_in,
	ir_pwd_char_if.source           char_out,
	input  logic                    cfg_we,
	input  ir_pwd_pkg::cfg_index_t  cfg_index,
	input  ir_pwd_pkg::cfg_data_t   cfg_wdata
);
	import ir_pwd_pkg::*;

	logic [7:0] start_threshold_q;
	logic [3:0] level_q;
	logic [1:0] band_q;
	logic       mono_q;

	msg_req_t   msg_req;
	logic       msg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_threshold_q <= StartThresholdReset;
			level_q           <= LevelReset;
			band_q            <= BandReset;
			mono_q            <= MonoReset;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgStartThreshold: start_threshold_q <= cfg_wdata;
				CfgLevel:          level_q <= cfg_wdata[3:0];
				CfgBand:           band_q <= cfg_wdata[1:0];
				CfgMono:           mono_q <= cfg_wdata[0];
				default:           ;
			endcase
		end
	end

	ir_pwd_frame u_frame (
		.clk             (clk),
		.arst_n          (arst_n),
		.edge_in         (edge_in),
		.start_threshold (start_threshold_q),
		.msg_ready       (msg_ready),
		.msg_req         (msg_req)
	);

	ir_pwd_msg u_msg (
		.clk           (clk),
		.arst_n        (arst_n),
		.msg_req       (msg_req),
		.msg_ready     (msg_ready),
		.level_setting (level_q),
		.band_setting  (band_q),
		.mono_setting  (mono_q),
		.char_out      (char_out)
	);

endmodule

// ===== tb/tb_ir_pulse_width_command_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR pulse-width command decoder testbench
// Drives receiver edge requests through the edge channel and checks every
// command byte against a local decoder model. The model tracks the frame
// state and the register settings. Directed edges cover idle and in-frame
// corner cases. Frames cover the first and last buttons, the register
// extremes and the repeat rules. A random phase then mixes well-formed frames
// with noise and broken frames. Both channels idle at random outside the repeat checks.
// ----------------------------------------------------------------------------
module tb_ir_pulse_width_command_decoder;
	import ir_pwd_pkg::*;

	localparam int FrameLen = 12;
	localparam int KeyCount = 9;
	localparam int SettleCycles = 8;
	localparam int ItemTarget = 230;
	localparam logic [7:0] CharZero = 8'h30;
	localparam logic [7:0] CharUpperA = 8'h41;
	localparam logic [7:0] CharNewline = 8'h0A;

	localparam logic [11:0] KeyCodes [KeyCount] = '{
		12'h010, 12'h810, 12'h410, 12'hC10, 12'h210,
		12'hA10, 12'h610, 12'hE10, 12'h110
	};
	localparam int KeyFreqs [KeyCount] = '{768, 774, 783, 789, 803, 809, 816, 822, 828};

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} cmd_char_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	cfg_index_t cfg_index;
	cfg_data_t cfg_wdata;

	ir_pwd_edge_if edge_if ();
	ir_pwd_char_if char_if ();

	ir_pulse_width_command_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.edge_in   (edge_if),
		.char_out  (char_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Local copy of the decoder state and registers.
	logic        receiving;
	logic [7:0]  low_len;
	logic [7:0]  high_len;
	logic [3:0]  bits_seen;
	logic [11:0] shift_reg;
	logic [11:0] prev_frame;
	logic [11:0] sent_code;
	logic [7:0]  start_thr;
	logic [3:0]  level_cfg;
	logic [1:0]  band_cfg;
	logic        mono_cfg;

	cmd_char_t pending_chars [$];
	int error_count;
	int edges_sent;
	int chars_checked;
	int settings_used;
	bit steady_flow;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		return (v <= 4'd9) ? CharZero + 8'(v) : CharUpperA + 8'(v) - 8'd10;
	endfunction

	function automatic void queue_message(input int key);
		logic [7:0] msg [7];
		int freq;
		freq = KeyFreqs[key];
		msg[0] = CharZero + 8'((freq / 100) % 10);
		msg[1] = CharZero + 8'((freq / 10) % 10);
		msg[2] = CharZero + 8'(freq % 10);
		msg[3] = hex_digit(level_cfg);
		msg[4] = hex_digit({band_cfg, 2'b00});
		msg[5] = CharZero + 8'(mono_cfg);
		msg[6] = CharNewline;
		for (int n = 0; n < 7; n++) begin
			pending_chars.push_back('{ch: msg[n], last: (n == 6)});
		end
	endfunction

	// Advances the local decoder by one accepted edge and queues any message.
	function automatic void advance_decoder(input logic rising, input logic [7:0] ticks);
		logic bit_val;
		int key;
		if (rising) begin
			low_len = ticks;
		end else begin
			high_len = ticks;
		end
		if (!receiving) begin
			if (rising && low_len > start_thr) begin
				receiving = 1'b1;
				bits_seen = 4'd0;
				shift_reg = 12'd0;
			end
		end else if (rising) begin
			// Nine-bit compare so that twice the high time never wraps.
			bit_val = {1'b0, low_len} > {high_len, 1'b0};
			shift_reg = {shift_reg[10:0], bit_val};
			bits_seen = bits_seen + 4'd1;
			if (bits_seen == 4'(FrameLen)) begin
				if (shift_reg == prev_frame && shift_reg != sent_code) begin
					sent_code = shift_reg;
					key = -1;
					for (int i = 0; i < KeyCount; i++) begin
						if (key < 0 && shift_reg == KeyCodes[i]) begin
							key = i;
						end
					end
					if (key >= 0) begin
						queue_message(key);
					end
				end
				prev_frame = shift_reg;
				receiving = 1'b0;
			end
		end
	endfunction

	// Sends one edge request; returns at the clock edge that accepted it.
	task automatic send_edge(input logic rising, input logic [7:0] ticks);
		while (!steady_flow && $urandom_range(0, 99) < 27) begin
			edge_if.valid <= 1'b0;
			@(posedge clk);
		end
		edge_if.valid <= 1'b1;
		edge_if.pin_level <= rising;
		edge_if.interval <= ticks;
		do @(negedge clk); while (!edge_if.ready);
		@(posedge clk);
		advance_decoder(rising, ticks);
		edges_sent++;
	endtask

	// Holds off new requests until every queued byte has come out.
	task automatic drain();
		edge_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input cfg_data_t data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CfgStartThreshold: start_thr = data;
			CfgLevel:          level_cfg = data[3:0];
			CfgBand:           band_cfg = data[1:0];
			CfgMono:           mono_cfg = data[0];
			default:           ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] thr, input logic [3:0] lvl,
			input logic [1:0] band, input logic mono);
		drain();
		write_reg(CfgStartThreshold, thr);
		write_reg(CfgLevel, cfg_data_t'(lvl));
		write_reg(CfgBand, cfg_data_t'(band));
		write_reg(CfgMono, cfg_data_t'(mono));
		settings_used++;
	endtask

	// Sends a start edge and the first nbits bits of code, MSB first.
	task automatic send_frame(input logic [11:0] code, input int nbits);
		logic [7:0] high_t;
		logic [7:0] low_t;
		int i;
		// Any frame left open by noise is finished off first.
		while (receiving) begin
			send_edge(1'b1, 8'($urandom_range(0, 255)));
		end
		send_edge(1'b0, 8'($urandom_range(0, 255)));
		if (start_thr == 8'd255) begin
			send_edge(1'b1, 8'd255);
		end else begin
			send_edge(1'b1, 8'($urandom_range(int'(start_thr) + 1, 255)));
		end
		for (i = FrameLen - 1; i >= FrameLen - nbits; i--) begin
			// The high time carries over to the next bit unless a falling edge is sent.
			if ($urandom_range(0, 3) == 0 || (code[i] && high_len > 8'd127)) begin
				if (code[i] || $urandom_range(0, 9) != 0) begin
					high_t = 8'($urandom_range(0, 127));
				end else begin
					high_t = 8'($urandom_range(128, 255));
				end
				send_edge(1'b0, high_t);
			end
			if (code[i]) begin
				low_t = 8'($urandom_range(2 * int'(high_len) + 1, 255));
			end else if (high_len > 8'd127) begin
				low_t = 8'($urandom_range(0, 255));
			end else begin
				low_t = 8'($urandom_range(0, 2 * int'(high_len)));
			end
			send_edge(1'b1, low_t);
		end
	endtask

	task automatic send_confirmed(input logic [11:0] code);
		send_frame(code, FrameLen);
		send_frame(code, FrameLen);
	endtask

	task automatic test_idle_edges();
		send_edge(1'b0, 8'd0);
		send_edge(1'b0, 8'd255);
		send_edge(1'b1, 8'd0);
		send_edge(1'b1, 8'd72);
		send_edge(1'b0, 8'd10);
		send_edge(1'b1, 8'd73);
		// In frame: falling edges only set the high time.
		send_edge(1'b0, 8'd255);
		send_edge(1'b0, 8'd255);
		send_edge(1'b1, 8'd255);
		send_edge(1'b0, 8'd0);
		send_edge(1'b1, 8'd0);
		send_edge(1'b1, 8'd1);
		send_edge(1'b0, 8'd127);
		send_edge(1'b1, 8'd255);
		send_edge(1'b1, 8'd254);
		send_edge(1'b0, 8'd128);
		send_edge(1'b1, 8'd255);
	endtask

	task automatic test_button_settings();
		set_config(8'd0, 4'd0, 2'd0, 1'b0);
		send_confirmed(KeyCodes[0]);
		set_config(8'd254, 4'd15, 2'd3, 1'b1);
		send_confirmed(KeyCodes[KeyCount - 1]);
	endtask

	task automatic test_threshold_max();
		set_config(8'd255, 4'd9, 2'd1, 1'b0);
		send_frame(KeyCodes[4], FrameLen);
		set_config(8'd72, 4'd3, 2'd1, 1'b0);
	endtask

	task automatic test_repeat_rules();
		// The last button is already sent, so one more copy stays silent.
		send_frame(KeyCodes[KeyCount - 1], FrameLen);
		send_confirmed(12'h123);
		send_confirmed(KeyCodes[KeyCount - 1]);
	endtask

	task automatic test_random_traffic();
		int rounds;
		int choice;
		int count;
		rounds = 0;
		while (edges_sent < ItemTarget) begin
			rounds++;
			if (rounds % 3 == 1) begin
				set_config(8'($urandom_range(0, 160)), 4'($urandom_range(0, 15)),
					2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
			end
			choice = $urandom_range(0, 99);
			if (choice < 65) begin
				send_confirmed(KeyCodes[$urandom_range(0, KeyCount - 1)]);
			end else if (choice < 78) begin
				send_confirmed(12'($urandom_range(0, 4095)));
			end else if (choice < 88) begin
				send_frame(($urandom_range(0, 1) != 0) ? KeyCodes[$urandom_range(0, 8)]
					: 12'($urandom_range(0, 4095)), FrameLen);
			end else if (choice < 95) begin
				count = $urandom_range(1, 6);
				repeat (count) begin
					send_edge(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
				end
			end else begin
				send_frame(12'($urandom_range(0, 4095)), $urandom_range(0, FrameLen - 1));
			end
		end
	endtask

	always @(posedge clk) begin
		char_if.ready <= steady_flow || ($urandom_range(0, 99) >= 27);
	end

	// Sampled on the falling clock edge ahead of the rising edge that completes the request.
	always @(negedge clk) begin
		if (arst_n && char_if.valid && char_if.ready) begin
			if (pending_chars.size() == 0) begin
				$display("%0t: unexpected byte: expected none, actual char %h last %b",
					$time, char_if.out_char, char_if.last_char);
				error_count++;
			end else begin
				if (char_if.out_char !== pending_chars[0].ch) begin
					$display("%0t: out_char mismatch: expected %h, actual %h",
						$time, pending_chars[0].ch, char_if.out_char);
					error_count++;
				end
				if (char_if.last_char !== pending_chars[0].last) begin
					$display("%0t: last_char mismatch: expected %b, actual %b",
						$time, pending_chars[0].last, char_if.last_char);
					error_count++;
				end
				void'(pending_chars.pop_front());
				chars_checked++;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CfgStartThreshold;
		cfg_wdata = '0;
		edge_if.valid = 1'b0;
		edge_if.pin_level = 1'b0;
		edge_if.interval = 8'd0;
		char_if.ready = 1'b0;
		steady_flow = 1'b0;
		error_count = 0;
		edges_sent = 0;
		chars_checked = 0;
		settings_used = 1;
		receiving = 1'b0;
		low_len = 8'd0;
		high_len = 8'd0;
		bits_seen = 4'd0;
		shift_reg = 12'd0;
		prev_frame = 12'd0;
		sent_code = 12'd0;
		start_thr = 8'd72;
		level_cfg = 4'd3;
		band_cfg = 2'd1;
		mono_cfg = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_edges();
		test_button_settings();
		test_threshold_max();
		// Both channels run without a gap through the repeat checks.
		steady_flow = 1'b1;
		test_repeat_rules();
		steady_flow = 1'b0;
		test_random_traffic();
		drain();

		$display("Sent %0d edge requests and checked %0d command bytes (%0d messages).",
			edges_sent, chars_checked, chars_checked / 7);
		$display("Ran under %0d register settings, including threshold and field extremes.",
			settings_used);
		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
